// ===== hw/rtl/irb_pkg.sv =====
package irb_pkg;

    localparam int SENSORS_DEF = 16;
    localparam int W_BITS      = 24;
    localparam int XW          = 38;
    localparam int ZW          = 28;
    localparam int CORDIC_IT   = 16;

    localparam logic signed [ZW-1:0] FULL_TURN    = 28'sd23592960;
    localparam logic signed [ZW-1:0] HALF_TURN    = 28'sd11796480;
    localparam logic signed [ZW-1:0] QUARTER_TURN = 28'sd5898240;
    localparam longint FULL_TURN_L = 64'd23592960;

    localparam logic [2:0] CFG_ACTIVE_LOW = 3'd0;
    localparam logic [2:0] CFG_WINDOW     = 3'd1;
    localparam logic [2:0] CFG_SIGNALS    = 3'd2;
    localparam logic [2:0] CFG_GAIN0      = 3'd3;
    localparam logic [2:0] CFG_GAIN1      = 3'd4;
    localparam logic [2:0] CFG_GAIN2      = 3'd5;
    localparam logic [2:0] CFG_GAIN3      = 3'd6;

    typedef enum logic {
        CM_ROTATE,
        CM_VECTOR
    } t_cmode;

    function automatic logic signed [ZW-1:0] atan_of(input logic [3:0] idx);
        logic signed [ZW-1:0] v;
        case (idx)
            4'd0:    v = 28'sd2949120;
            4'd1:    v = 28'sd1740967;
            4'd2:    v = 28'sd919879;
            4'd3:    v = 28'sd466945;
            4'd4:    v = 28'sd234379;
            4'd5:    v = 28'sd117304;
            4'd6:    v = 28'sd58666;
            4'd7:    v = 28'sd29335;
            4'd8:    v = 28'sd14668;
            4'd9:    v = 28'sd7334;
            4'd10:   v = 28'sd3667;
            4'd11:   v = 28'sd1833;
            4'd12:   v = 28'sd917;
            4'd13:   v = 28'sd458;
            4'd14:   v = 28'sd229;
            default: v = 28'sd115;
        endcase
        return v;
    endfunction

endpackage

// ===== hw/rtl/ir_bearing_estimator.sv =====
// IR bearing estimator: each accepted beat is one sample tick with all sensor
// levels. The tick that fills the window starts the result pass and stalls
// the input until that result is in the output register: the per-sensor duty
// dividers (one per lane, side by side), the weight sum over all sensors, then
// per used sensor a scan over all sensors plus a CORDIC rotation, then
// vectoring, a magnitude step and the strength math. A finished result waits
// in the output register while ticks keep coming in.
module ir_bearing_estimator #(
    parameter int SENSORS = irb_pkg::SENSORS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [15:0] i_sensor_levels,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [14:0] o_bearing,
    output logic [28:0] o_confidence,
    output logic [14:0] o_raw_strength,
    output logic [14:0] o_filtered_strength
);

    localparam int WB = irb_pkg::W_BITS;

    logic            r_active_low;
    logic [15:0]     r_window;
    logic [4:0]      r_k;
    logic [3:0][63:0] r_gain;
    logic [15:0]     r_ticks;
    logic            r_busy;
    logic            r_start;
    logic            r_out_valid;
    logic [14:0]     r_bearing;
    logic [28:0]     r_conf;
    logic [14:0]     r_raw;
    logic [14:0]     r_filt;

    logic            tick;
    logic [15:0]     levels;
    logic [15:0]     n_ticks;
    logic            res_valid;
    logic            take;
    logic [14:0]     m_bearing;
    logic [28:0]     m_conf;
    logic [14:0]     m_raw;
    logic [14:0]     m_filt;
    logic [SENSORS-1:0]          lane_done;
    logic [SENSORS-1:0][WB-1:0]  weights;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_busy;
    assign tick        = i_in_valid && !r_busy;
    assign levels      = i_sensor_levels ^ {16{r_active_low}};
    assign n_ticks     = (r_ticks == 16'hFFFF) ? r_ticks : r_ticks + 1'b1;
    assign take        = res_valid && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_low <= 1'b0;
            r_window     <= 16'd100;
            r_k          <= 5'd3;
            r_gain       <= {4{64'h0100_0100_0100_0100}};
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                irb_pkg::CFG_ACTIVE_LOW: r_active_low <= i_cfg_data[0];
                irb_pkg::CFG_WINDOW:     r_window     <= i_cfg_data[15:0];
                irb_pkg::CFG_SIGNALS:    r_k          <= i_cfg_data[4:0];
                irb_pkg::CFG_GAIN0:      r_gain[0]    <= i_cfg_data;
                irb_pkg::CFG_GAIN1:      r_gain[1]    <= i_cfg_data;
                irb_pkg::CFG_GAIN2:      r_gain[2]    <= i_cfg_data;
                irb_pkg::CFG_GAIN3:      r_gain[3]    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks     <= '0;
            r_busy      <= 1'b0;
            r_start     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_start <= 1'b0;
            if (r_start) begin
                r_ticks <= '0;
            end else if (tick) begin
                r_ticks <= n_ticks;
                if (n_ticks >= r_window) begin
                    r_busy  <= 1'b1;
                    r_start <= 1'b1;
                end
            end
            if (take) begin
                r_busy      <= 1'b0;
                r_out_valid <= 1'b1;
                r_bearing   <= m_bearing;
                r_conf      <= m_conf;
                r_raw       <= m_raw;
                r_filt      <= m_filt;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    genvar g;
    generate
        for (g = 0; g < SENSORS; g++) begin : g_lane
            irb_lane u_lane (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_tick   (tick),
                .i_level  (levels[g]),
                .i_start  (r_start),
                .i_ticks  (r_ticks),
                .i_gain   (r_gain[g / 4][(g % 4) * 16 +: 16]),
                .o_weight (weights[g]),
                .o_done   (lane_done[g])
            );
        end
    endgenerate

    irb_merge #(.SENSORS(SENSORS)) u_merge (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_start             (&lane_done),
        .i_weights           (weights),
        .i_k                 (r_k),
        .i_take              (take),
        .o_res_valid         (res_valid),
        .o_bearing           (m_bearing),
        .o_confidence        (m_conf),
        .o_raw_strength      (m_raw),
        .o_filtered_strength (m_filt)
    );

    assign o_out_valid         = r_out_valid;
    assign o_bearing           = r_bearing;
    assign o_confidence        = r_conf;
    assign o_raw_strength      = r_raw;
    assign o_filtered_strength = r_filt;

endmodule

// ===== hw/rtl/irb_div.sv =====
module irb_div #(
    parameter int DW = 40,
    parameter int VW = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quot
);

    localparam int CW = $clog2(DW);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [VW-1:0] r_rem;
    logic [VW-1:0] r_dvs;
    logic [DW-1:0] r_quo;
    logic [VW:0]   trial;
    logic          fits;

    assign trial = {r_rem, r_quo[DW-1]};
    assign fits  = trial >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_dvs  <= i_divisor;
                r_quo  <= i_dividend;
            end else if (r_busy) begin
                r_rem <= fits ? VW'(trial - {1'b0, r_dvs}) : trial[VW-1:0];
                r_quo <= {r_quo[DW-2:0], fits};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(DW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

// ===== hw/rtl/irb_lane.sv =====
module irb_lane (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_tick,
    input  logic                        i_level,
    input  logic                        i_start,
    input  logic [15:0]                 i_ticks,
    input  logic [15:0]                 i_gain,
    output logic [irb_pkg::W_BITS-1:0]  o_weight,
    output logic                        o_done
);

    logic [15:0] r_count;
    logic [31:0] r_prod;
    logic [15:0] r_dvs;
    logic        r_go;
    logic [39:0] quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_go    <= 1'b0;
        end else begin
            r_go <= 1'b0;
            if (i_start) begin
                r_prod  <= r_count * i_gain;
                r_dvs   <= i_ticks;
                r_count <= '0;
                r_go    <= 1'b1;
            end else if (i_tick && i_level && r_count != 16'hFFFF) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    irb_div #(.DW(40), .VW(16)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_go),
        .i_dividend ({r_prod, 8'd0}),
        .i_divisor  (r_dvs),
        .o_done     (o_done),
        .o_quot     (quot)
    );

    // count never exceeds ticks, so the weight stays below 2^24
    assign o_weight = quot[irb_pkg::W_BITS-1:0];

endmodule

// ===== hw/rtl/irb_cordic.sv =====
module irb_cordic (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  irb_pkg::t_cmode                  i_mode,
    input  logic signed [irb_pkg::XW-1:0]    i_x,
    input  logic signed [irb_pkg::XW-1:0]    i_y,
    input  logic signed [irb_pkg::ZW-1:0]    i_z,
    output logic                             o_done,
    output logic signed [irb_pkg::XW-1:0]    o_x,
    output logic signed [irb_pkg::XW-1:0]    o_y,
    output logic signed [irb_pkg::ZW-1:0]    o_z
);

    localparam int XW = irb_pkg::XW;
    localparam int ZW = irb_pkg::ZW;

    logic                 r_busy;
    logic                 r_done;
    irb_pkg::t_cmode      r_mode;
    logic [3:0]           r_it;
    logic signed [XW-1:0] r_x;
    logic signed [XW-1:0] r_y;
    logic signed [ZW-1:0] r_z;

    logic signed [XW-1:0] px;
    logic signed [XW-1:0] py;
    logic signed [ZW-1:0] pz;
    logic signed [ZW-1:0] z0;
    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;
    logic                 dir;

    always_comb begin
        z0 = (i_z > irb_pkg::HALF_TURN) ? i_z - irb_pkg::FULL_TURN : i_z;
        py = i_y;
        if (i_mode == irb_pkg::CM_ROTATE) begin
            if (z0 > irb_pkg::QUARTER_TURN) begin
                pz = z0 - irb_pkg::HALF_TURN;
                px = -i_x;
            end else if (z0 < -irb_pkg::QUARTER_TURN) begin
                pz = z0 + irb_pkg::HALF_TURN;
                px = -i_x;
            end else begin
                pz = z0;
                px = i_x;
            end
        end else begin
            if (i_x < 0) begin
                px = -i_x;
                py = -i_y;
                pz = irb_pkg::HALF_TURN;
            end else begin
                px = i_x;
                pz = '0;
            end
        end
    end

    assign dx  = r_y >>> r_it;
    assign dy  = r_x >>> r_it;
    assign dir = (r_mode == irb_pkg::CM_ROTATE) ? (r_z >= 0) : (r_y < 0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_mode <= i_mode;
                r_it   <= '0;
                r_x    <= px;
                r_y    <= py;
                r_z    <= pz;
            end else if (r_busy) begin
                if (dir) begin
                    r_x <= r_x - dx;
                    r_y <= r_y + dy;
                    r_z <= r_z - irb_pkg::atan_of(r_it);
                end else begin
                    r_x <= r_x + dx;
                    r_y <= r_y - dy;
                    r_z <= r_z + irb_pkg::atan_of(r_it);
                end
                r_it <= r_it + 1'b1;
                if (r_it == 4'(irb_pkg::CORDIC_IT - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;

endmodule

// ===== hw/rtl/irb_merge.sv =====
module irb_merge #(
    parameter int SENSORS = irb_pkg::SENSORS_DEF
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_start,
    input  logic [SENSORS-1:0][irb_pkg::W_BITS-1:0]    i_weights,
    input  logic [4:0]                                 i_k,
    input  logic                                       i_take,
    output logic                                       o_res_valid,
    output logic [14:0]                                o_bearing,
    output logic [28:0]                                o_confidence,
    output logic [14:0]                                o_raw_strength,
    output logic [14:0]                                o_filtered_strength
);

    localparam int XW = irb_pkg::XW;
    localparam int ZW = irb_pkg::ZW;
    localparam int WB = irb_pkg::W_BITS;
    localparam int IW = $clog2(SENSORS);
    localparam logic [35:0] OFFSET  = 36'(64'd1310720 * SENSORS);
    localparam logic [15:0] RAW_DIV = 16'(384 * SENSORS);
    // reciprocal of the strength divisor, exact below the clamp limit
    localparam logic [31:0] RAW_M   =
        32'(((64'd1 << 41) + 64'(RAW_DIV) - 64'd1) / 64'(RAW_DIV));
    localparam logic [37:0] RAW_LIM = 38'(64'd25601 * 64'(RAW_DIV));
    // ceil(2^29 / 5), exact for the whole average range
    localparam logic [26:0] AVG_M   = 27'd107374183;

    typedef enum logic [3:0] {
        M_IDLE, M_SUM, M_SCAN, M_PRE, M_ROT, M_VEC, M_VWAIT,
        M_MAG, M_RAW, M_RDIV, M_AVG, M_ADIV, M_HOLD
    } t_mstate;

    t_mstate              r_state;
    logic [IW-1:0]        r_idx;
    logic [27:0]          r_sum;
    logic [SENSORS-1:0]   r_chosen;
    logic [WB-1:0]        r_bw;
    logic [IW-1:0]        r_best;
    logic                 r_found;
    logic [4:0]           r_round;
    logic signed [XW-1:0] r_sx;
    logic signed [XW-1:0] r_sy;
    logic signed [XW-1:0] r_mag;
    logic [14:0]          r_bearing;
    logic [28:0]          r_conf;
    logic [14:0]          r_raw;
    logic [23:0]          r_avg;
    logic [37:0]          r_rnum;
    logic [26:0]          r_avg_d;

    logic [SENSORS-1:0][ZW-1:0] ang;

    genvar g;
    generate
        for (g = 0; g < SENSORS; g++) begin : g_ang
            localparam longint A =
                ((longint'(g + 1) * irb_pkg::FULL_TURN_L) + SENSORS / 2) / SENSORS
                % irb_pkg::FULL_TURN_L;
            assign ang[g] = ZW'(A);
        end
    endgenerate

    logic [WB-1:0]        w_cur;
    logic                 cand;
    logic [WB-1:0]        n_bw;
    logic [IW-1:0]        n_best;
    logic                 n_found;
    logic                 last_idx;
    logic [39:0]          rot_prod;
    logic signed [XW-1:0] rot_x;

    assign w_cur    = i_weights[r_idx];
    assign cand     = !r_chosen[r_idx] && (w_cur > r_bw);
    assign n_bw     = cand ? w_cur : r_bw;
    assign n_best   = cand ? r_idx : r_best;
    assign n_found  = cand || r_found;
    assign last_idx = r_idx == IW'(SENSORS - 1);
    assign rot_prod = r_bw * 40'd39797;
    assign rot_x    = XW'(rot_prod[39:16]);

    logic                 cor_start;
    irb_pkg::t_cmode      cor_mode;
    logic                 cor_done;
    logic signed [XW-1:0] cor_x;
    logic signed [XW-1:0] cor_y;
    logic signed [ZW-1:0] cor_z;
    logic                 vec_zero;

    assign vec_zero  = (r_sx == 0) && (r_sy == 0);
    assign cor_mode  = (r_state == M_PRE) ? irb_pkg::CM_ROTATE : irb_pkg::CM_VECTOR;
    assign cor_start = (r_state == M_PRE) || (r_state == M_VEC && !vec_zero);

    irb_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cor_start),
        .i_mode  (cor_mode),
        .i_x     ((r_state == M_PRE) ? rot_x : r_sx),
        .i_y     ((r_state == M_PRE) ? '0 : r_sy),
        .i_z     ((r_state == M_PRE) ? $signed(ang[r_best]) : '0),
        .o_done  (cor_done),
        .o_x     (cor_x),
        .o_y     (cor_y),
        .o_z     (cor_z)
    );

    // bearing from vector angle, rounded to 1/64 degree
    logic signed [ZW-1:0] ba;
    logic signed [ZW-1:0] bn;
    always_comb begin
        ba = (cor_z + ZW'(512)) >>> 10;
        if (ba > ZW'(11520)) begin
            bn = ba - ZW'(23040);
        end else if (ba <= -ZW'(11520)) begin
            bn = ba + ZW'(23040);
        end else begin
            bn = ba;
        end
    end

    logic signed [XW+16:0] mprod;
    logic signed [XW+16:0] mshift;
    assign mprod  = $signed({{17{r_mag[XW-1]}}, r_mag}) * $signed({{XW{1'b0}}, 17'd39797});
    assign mshift = mprod >>> 16;

    logic [35:0] num;
    logic        num_big;
    logic [58:0] raw_prod;
    logic [53:0] avg_prod;

    assign num      = 36'(r_sum) * 36'd100;
    assign num_big  = num > OFFSET;
    assign raw_prod = 59'(r_rnum[27:0]) * 59'(RAW_M);
    assign avg_prod = 54'(r_avg_d) * 54'(AVG_M);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_avg   <= '0;
        end else begin
            case (r_state)
                M_IDLE: begin
                    if (i_start) begin
                        r_idx    <= '0;
                        r_sum    <= '0;
                        r_chosen <= '0;
                        r_round  <= '0;
                        r_sx     <= '0;
                        r_sy     <= '0;
                        r_state  <= M_SUM;
                    end
                end
                M_SUM: begin
                    r_sum <= r_sum + 28'(w_cur);
                    r_idx <= r_idx + 1'b1;
                    if (last_idx) begin
                        r_idx   <= '0;
                        r_bw    <= '0;
                        r_best  <= '0;
                        r_found <= 1'b0;
                        r_state <= (i_k == 5'd0) ? M_VEC : M_SCAN;
                    end
                end
                M_SCAN: begin
                    r_bw    <= n_bw;
                    r_best  <= n_best;
                    r_found <= n_found;
                    r_idx   <= r_idx + 1'b1;
                    if (last_idx) begin
                        if (n_found) begin
                            r_chosen[n_best] <= 1'b1;
                            r_state          <= M_PRE;
                        end else begin
                            r_state <= M_VEC;
                        end
                    end
                end
                M_PRE: begin
                    r_state <= M_ROT;
                end
                M_ROT: begin
                    if (cor_done) begin
                        r_sx    <= r_sx + cor_x;
                        r_sy    <= r_sy + cor_y;
                        r_round <= r_round + 1'b1;
                        r_idx   <= '0;
                        r_bw    <= '0;
                        r_found <= 1'b0;
                        r_state <= (r_round + 5'd1 == i_k) ? M_VEC : M_SCAN;
                    end
                end
                M_VEC: begin
                    if (vec_zero) begin
                        r_bearing <= '0;
                        r_conf    <= '0;
                        r_state   <= M_RAW;
                    end else begin
                        r_state <= M_VWAIT;
                    end
                end
                M_VWAIT: begin
                    if (cor_done) begin
                        r_bearing <= bn[14:0];
                        r_mag     <= cor_x;
                        r_state   <= M_MAG;
                    end
                end
                M_MAG: begin
                    if (mshift < 0) begin
                        r_conf <= '0;
                    end else if (mshift > (XW+17)'(29'h1000_0000)) begin
                        r_conf <= 29'h1000_0000;
                    end else begin
                        r_conf <= mshift[28:0];
                    end
                    r_state <= M_RAW;
                end
                M_RAW: begin
                    r_rnum  <= num_big ? 38'(38'(num - OFFSET) * 38'd5) : '0;
                    r_state <= M_RDIV;
                end
                M_RDIV: begin
                    r_raw   <= (r_rnum >= RAW_LIM) ? 15'd25600 : raw_prod[55:41];
                    r_state <= M_AVG;
                end
                M_AVG: begin
                    r_avg_d <= 27'({r_avg, 2'b00}) + 27'({r_raw, 8'd0}) + 27'd2;
                    r_state <= M_ADIV;
                end
                M_ADIV: begin
                    r_avg   <= avg_prod[52:29];
                    r_state <= M_HOLD;
                end
                M_HOLD: begin
                    if (i_take) begin
                        r_state <= M_IDLE;
                    end
                end
                default: begin
                    r_state <= M_IDLE;
                end
            endcase
        end
    end

    logic [24:0] avg_rnd;
    assign avg_rnd = 25'(r_avg) + 25'd128;

    assign o_res_valid         = r_state == M_HOLD;
    assign o_bearing           = r_bearing;
    assign o_confidence        = r_conf;
    assign o_raw_strength      = r_raw;
    assign o_filtered_strength = avg_rnd[22:8];

endmodule

// ===== hw/rtl/irb_checker.sv =====
module irb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [14:0] o_bearing,
    input logic [28:0] o_confidence,
    input logic [14:0] o_raw_strength,
    input logic [14:0] o_filtered_strength
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_bearing) && $stable(o_confidence)
            && $stable(o_raw_strength) && $stable(o_filtered_strength))
        else $error("result changed while stalled");

    a_bearing_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ($signed(o_bearing) > -15'sd11520)
            && ($signed(o_bearing) <= 15'sd11520))
        else $error("bearing out of range");

    a_strength_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_raw_strength <= 15'd25600)
            && (o_filtered_strength <= 15'd25600)
            && (o_confidence <= 29'h1000_0000))
        else $error("strength out of range");

endmodule

bind ir_bearing_estimator irb_checker u_irb_checker (.*);

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

    localparam int NS = 16;
    localparam longint TURN = 64'd23592960;
    localparam longint HALF = 64'd11796480;
    localparam longint QUART = 64'd5898240;
    localparam longint GAIN_FIX = 39797;

    typedef struct packed {
        logic [14:0] bearing;
        logic [28:0] confidence;
        logic [14:0] raw_strength;
        logic [14:0] filtered_strength;
    } t_reading;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = irb_pkg::CFG_ACTIVE_LOW;
    logic [63:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [15:0] i_sensor_levels = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [14:0] o_bearing;
    logic [28:0] o_confidence;
    logic [14:0] o_raw_strength;
    logic [14:0] o_filtered_strength;

    ir_bearing_estimator dut (.*);

    // predictor state and configuration
    logic        cur_active_low;
    logic [15:0] cur_window;
    logic [4:0]  cur_signals;
    logic [63:0] cur_gain [4];
    logic [15:0] duty_count [NS];
    logic [15:0] tick_count;
    logic [23:0] avg_strength;

    t_reading pending_readings [$];
    int errors = 0;
    int hold_off = 0;
    int stall_pct = 30;
    bit sender_gaps = 1'b1;
    int burst_left = 0;
    int sensor_prob [NS];

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("ir_bearing_estimator: mismatch");
        $finish;
    end

    task automatic report(input string what, input longint got, input longint want);
        $display("%0t %s got %0d want %0d", $realtime, what, got, want);
        errors++;
    endtask

    task automatic rotate(input longint w, input longint ang, output longint xo,
                          output longint yo);
        longint x, y, z, dx, dy;
        x = (w * GAIN_FIX) >>> 16;
        y = 0;
        z = ang;
        if (z > HALF) z -= TURN;
        if (z > QUART) begin
            z -= HALF;
            x = -x;
        end else if (z < -QUART) begin
            z += HALF;
            x = -x;
        end
        for (int i = 0; i < 16; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(irb_pkg::atan_of(4'(i)));
            end else begin
                x += dx; y -= dy; z += longint'(irb_pkg::atan_of(4'(i)));
            end
        end
        xo = x;
        yo = y;
    endtask

    task automatic vectorize(input longint xi, input longint yi, output longint ang,
                             output longint mag);
        longint x, y, z, dx, dy;
        x = xi;
        y = yi;
        z = 0;
        if (x < 0) begin
            x = -x; y = -y; z = HALF;
        end
        for (int i = 0; i < 16; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x += dx; y -= dy; z += longint'(irb_pkg::atan_of(4'(i)));
            end else begin
                x -= dx; y += dy; z -= longint'(irb_pkg::atan_of(4'(i)));
            end
        end
        ang = z;
        mag = x;
    endtask

    task automatic predict_tick(input logic [15:0] levels);
        logic [15:0] lv;
        longint w [NS];
        longint sum_w, sx, sy, px, py, ang, mag, brg, conf, raw, num, gain, bw;
        int best;
        logic [15:0] chosen;
        t_reading r;
        lv = cur_active_low ? ~levels : levels;
        for (int i = 0; i < NS; i++)
            if (lv[i] && duty_count[i] != 16'hFFFF) duty_count[i]++;
        if (tick_count != 16'hFFFF) tick_count++;
        if (tick_count < cur_window) return;
        sum_w = 0;
        for (int i = 0; i < NS; i++) begin
            gain = longint'(cur_gain[i / 4][16 * (i % 4) +: 16]);
            w[i] = (tick_count != 0) ? longint'(duty_count[i]) * gain * 256 / tick_count : 0;
            sum_w += w[i];
        end
        chosen = '0;
        sx = 0;
        sy = 0;
        for (int k = 0; k < cur_signals; k++) begin
            best = NS;
            bw = 0;
            for (int i = 0; i < NS; i++)
                if (!chosen[i] && w[i] > bw) begin
                    bw = w[i];
                    best = i;
                end
            if (best == NS) break;
            chosen[best] = 1'b1;
            ang = ((longint'(best) + 1) * TURN + NS / 2) / NS % TURN;
            rotate(bw, ang, px, py);
            sx += px;
            sy += py;
        end
        brg = 0;
        conf = 0;
        if (sx != 0 || sy != 0) begin
            vectorize(sx, sy, ang, mag);
            brg = (ang + 512) >>> 10;
            while (brg > 11520) brg -= 23040;
            while (brg <= -11520) brg += 23040;
            mag = (mag * GAIN_FIX) >>> 16;
            if (mag < 0) mag = 0;
            conf = (mag > (64'd1 << 28)) ? (64'd1 << 28) : mag;
        end
        num = 100 * sum_w;
        raw = 0;
        if (num > 64'd1310720 * NS) begin
            raw = 5 * (num - 64'd1310720 * NS) / (384 * NS);
            if (raw > 25600) raw = 25600;
        end
        avg_strength = 24'((4 * longint'(avg_strength) + raw * 256 + 2) / 5);
        r.bearing = brg[14:0];
        r.confidence = conf[28:0];
        r.raw_strength = raw[14:0];
        r.filtered_strength = 15'((longint'(avg_strength) + 128) >> 8);
        pending_readings.push_back(r);
        for (int i = 0; i < NS; i++) duty_count[i] = '0;
        tick_count = '0;
    endtask

    task automatic send_tick(input logic [15:0] levels);
        int gap;
        if (sender_gaps) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 12);
                gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                if (gap > 0) begin
                    i_in_valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            burst_left--;
        end
        i_in_valid <= 1'b1;
        i_sensor_levels <= levels;
        do @(posedge i_clk); while (o_in_stall);
        predict_tick(levels);
    endtask

    task automatic end_burst();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_idle();
        end_burst();
        while (pending_readings.size() != 0) @(posedge i_clk);
        repeat (1000) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            irb_pkg::CFG_ACTIVE_LOW: cur_active_low = data[0];
            irb_pkg::CFG_WINDOW:     cur_window = data[15:0];
            irb_pkg::CFG_SIGNALS:    cur_signals = data[4:0];
            irb_pkg::CFG_GAIN0:      cur_gain[0] = data;
            irb_pkg::CFG_GAIN1:      cur_gain[1] = data;
            irb_pkg::CFG_GAIN2:      cur_gain[2] = data;
            default:                 cur_gain[3] = data;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_gains(input logic [63:0] g0, g1, g2, g3);
        write_reg(irb_pkg::CFG_GAIN0, g0);
        write_reg(irb_pkg::CFG_GAIN1, g1);
        write_reg(irb_pkg::CFG_GAIN2, g2);
        write_reg(irb_pkg::CFG_GAIN3, g3);
    endtask

    function automatic logic [63:0] rand_gain();
        logic [63:0] g;
        for (int l = 0; l < 4; l++)
            case ($urandom_range(0, 5))
                0:       g[16 * l +: 16] = 16'h0000;
                1:       g[16 * l +: 16] = 16'hFFFF;
                2:       g[16 * l +: 16] = 16'h0100;
                default: g[16 * l +: 16] = 16'($urandom);
            endcase
        return g;
    endfunction

    function automatic logic [15:0] biased_levels();
        logic [15:0] v;
        for (int i = 0; i < NS; i++) v[i] = ($urandom_range(0, 99) < sensor_prob[i]);
        return v;
    endfunction

    // receiver stall pattern, plus a long hold-off when asked
    always @(posedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
        if ($urandom_range(0, 63) == 0)
            stall_pct <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 80);
    end

    always @(posedge i_clk) begin
        t_reading want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_readings.size() == 0) begin
                report("unexpected beat bearing", o_bearing, 0);
            end else begin
                want = pending_readings.pop_front();
                if (o_bearing !== want.bearing)
                    report("bearing", o_bearing, want.bearing);
                if (o_confidence !== want.confidence)
                    report("confidence", o_confidence, want.confidence);
                if (o_raw_strength !== want.raw_strength)
                    report("raw_strength", o_raw_strength, want.raw_strength);
                if (o_filtered_strength !== want.filtered_strength)
                    report("filtered_strength", o_filtered_strength, want.filtered_strength);
            end
        end
    end

    task automatic test_directed();
        write_reg(irb_pkg::CFG_WINDOW, 64'd1);
        send_tick(16'h0000);
        send_tick(16'hFFFF);
        send_tick(16'h0001);
        send_tick(16'h8000);
        send_tick(16'hAAAA);
        wait_idle();
        set_gains(64'hFFFF_0000_0100_FFFF, 64'h0001_FFFF_0000_0200,
                  64'h0100_0100_0100_0100, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(irb_pkg::CFG_ACTIVE_LOW, 64'd1);
        send_tick(16'h0000);
        send_tick(16'hFFFF);
        send_tick(16'h5A5A);
        wait_idle();
        write_reg(irb_pkg::CFG_ACTIVE_LOW, 64'd0);
        set_gains(64'h0100_0100_0100_0100, 64'h0100_0100_0100_0100,
                  64'h0100_0100_0100_0100, 64'h0100_0100_0100_0100);
        // no sensor summed, then more sensors asked than are lit
        write_reg(irb_pkg::CFG_SIGNALS, 64'd0);
        send_tick(16'hFFFF);
        wait_idle();
        write_reg(irb_pkg::CFG_SIGNALS, 64'd31);
        send_tick(16'h0101);
        send_tick(16'h0F0F);
        wait_idle();
        // equal weights, lower index first
        write_reg(irb_pkg::CFG_SIGNALS, 64'd1);
        send_tick(16'h8181);
        send_tick(16'h0101);
        wait_idle();
        write_reg(irb_pkg::CFG_WINDOW, 64'd0);
        send_tick(16'h1234);
        wait_idle();
        // window raised above the ticks sent, then lowered below the ticks already taken
        write_reg(irb_pkg::CFG_WINDOW, 64'd5);
        write_reg(irb_pkg::CFG_SIGNALS, 64'd16);
        send_tick(16'h00FF);
        send_tick(16'h0F00);
        wait_idle();
        write_reg(irb_pkg::CFG_WINDOW, 64'd1);
        send_tick(16'hF000);
        wait_idle();
    endtask

    task automatic test_saturation();
        sender_gaps = 1'b0;
        set_gains(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                  64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(irb_pkg::CFG_WINDOW, 64'd100);
        write_reg(irb_pkg::CFG_SIGNALS, 64'd3);
        for (int n = 0; n < 100; n++)
            send_tick((n % 7 == 0) ? 16'h0F0F : 16'hFFFF);
        wait_idle();
        sender_gaps = 1'b1;
    endtask

    task automatic test_random();
        int items;
        int wins;
        items = 0;
        while (items < 800) begin
            write_reg(irb_pkg::CFG_ACTIVE_LOW, 64'($urandom_range(0, 1)));
            case ($urandom_range(0, 9))
                0:       write_reg(irb_pkg::CFG_WINDOW, 64'd0);
                1:       write_reg(irb_pkg::CFG_WINDOW, 64'($urandom_range(20, 60)));
                default: write_reg(irb_pkg::CFG_WINDOW, 64'($urandom_range(1, 12)));
            endcase
            write_reg(irb_pkg::CFG_SIGNALS,
                      ($urandom_range(0, 4) == 0) ? 64'($urandom_range(0, 31))
                                                  : 64'($urandom_range(1, 6)));
            set_gains(rand_gain(), rand_gain(), rand_gain(), rand_gain());
            for (int i = 0; i < NS; i++)
                sensor_prob[i] = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 100)
                                                             : $urandom_range(0, 15);
            wins = $urandom_range(4, 10);
            for (int n = 0; n < wins * (cur_window == 0 ? 1 : cur_window); n++) begin
                send_tick(($urandom_range(0, 9) == 0) ? 16'($urandom) : biased_levels());
                items++;
            end
            wait_idle();
        end
    endtask

    task automatic test_backpressure();
        write_reg(irb_pkg::CFG_WINDOW, 64'd1);
        write_reg(irb_pkg::CFG_SIGNALS, 64'd4);
        hold_off = 2000;
        for (int n = 0; n < 30; n++) send_tick(16'($urandom));
        end_burst();
        // hold the sender until every result has drained
        while (pending_readings.size() != 0) @(posedge i_clk);
        for (int n = 0; n < 20; n++) send_tick(16'($urandom));
        wait_idle();
    endtask

    initial begin
        cur_active_low = 1'b0;
        cur_window = 16'd100;
        cur_signals = 5'd3;
        for (int i = 0; i < 4; i++) cur_gain[i] = 64'h0100_0100_0100_0100;
        for (int i = 0; i < NS; i++) duty_count[i] = '0;
        tick_count = '0;
        avg_strength = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_saturation();
        test_backpressure();
        test_random();
        wait_idle();
        if (errors == 0 && pending_readings.size() == 0) begin
            $display("ir_bearing_estimator: match");
        end else begin
            $display("ir_bearing_estimator: mismatch");
        end
        $finish;
    end

endmodule
